@@ rtl/imufd_pkg.sv @@
// Shared types, constants and scale-factor tables for the IMU FIFO packet deframer.
package imufd_pkg;

	// Packet framing
	localparam int unsigned PKT_BYTES = 13;
	localparam int unsigned POS_W     = 4;
	localparam logic [POS_W-1:0] PKT_LAST = POS_W'(PKT_BYTES - 1);
	localparam logic [POS_W-1:0] POS_FIRST_GYRO = POS_W'(8);

	// Header decode masks
	localparam logic [7:0] HDR_MARKER     = 8'h80;
	localparam logic [7:0] HDR_ACCEL_MASK = 8'h30;
	localparam logic [7:0] HDR_ACCEL_16B  = 8'h20;
	localparam logic [7:0] HDR_GYRO_MASK  = 8'h0C;
	localparam logic [7:0] HDR_GYRO_16B   = 8'h08;

	// Datapath widths
	localparam int unsigned AXIS_W   = 33;
	localparam int unsigned RAW_W    = 16;
	localparam int unsigned FACTOR_W = 33;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned RANGE_W  = 2;
	localparam int unsigned NUM_HELD = 5;  // axes stored before the last one arrives

	// Fixed point: factors are per-LSB scale in units of 2^-40
	localparam int unsigned FACTOR_FRAC = 40;
	localparam int unsigned FRAC_BITS_DEFAULT = 24;

	// Register reset values
	localparam logic [RANGE_W-1:0] GYRO_RANGE_RST  = 2'd1;
	localparam logic [RANGE_W-1:0] ACCEL_RANGE_RST = 2'd2;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_GYRO_RANGE  = 1'b0,
		REG_ACCEL_RANGE = 1'b1
	} reg_index_t;

	// Packet status codes
	typedef enum logic [1:0] {
		STAT_GOOD     = 2'd0,
		STAT_MARKER   = 2'd1,
		STAT_BAD_ENC  = 2'd2
	} pkt_status_t;

	// Request to the axis scaler
	typedef struct packed {
		logic signed [RAW_W-1:0] raw;
		logic                    is_gyro;
		logic [RANGE_W-1:0]      gyro_range;
		logic [RANGE_W-1:0]      accel_range;
	} scale_req_t;

	// Gyro factor: full scale deg/s in rad/s per LSB, times 2^40
	function automatic logic [FACTOR_W-1:0] gyro_factor(input logic [RANGE_W-1:0] rng);
		logic [FACTOR_W-1:0] f;
		case (rng)
			2'd0:    f = 33'd1171270634;
			2'd1:    f = 33'd585635317;
			2'd2:    f = 33'd292817659;
			2'd3:    f = 33'd146408829;
			default: f = 33'd585635317;
		endcase
		return f;
	endfunction

	// Accel factor: full scale g in m/s2 per LSB, times 2^40
	function automatic logic [FACTOR_W-1:0] accel_factor(input logic [RANGE_W-1:0] rng);
		logic [FACTOR_W-1:0] f;
		case (rng)
			2'd0:    f = 33'd5264905129;
			2'd1:    f = 33'd2632452565;
			2'd2:    f = 33'd1316226282;
			2'd3:    f = 33'd658113141;
			default: f = 33'd1316226282;
		endcase
		return f;
	endfunction

endpackage

@@ rtl/imu_fifo_packet_deframer.sv @@
// Top level of the IMU FIFO packet deframer: byte framing, axis scaling and result register.
// Usage:
//   Input channel (in_valid/in_ready, fifo_byte) takes one FIFO byte per request.
//   Every 13 bytes form a packet: header, accel X/Y/Z, gyro X/Y/Z, each axis
//   big-endian signed 16 bits. After the 13th byte one result request goes out
//   on the output channel (out_valid/out_ready) with status, six scaled axes
//   (zero when the header is bad) and saturating bad-header and packet counters.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets gyro_range
//   (index 0) and accel_range (index 1); always ready, write only while idle.
// Datapath:
//   One byte per cycle sustained while no held result stalls. Each byte is held
//   in the input register; a packet's result is registered when its last byte
//   leaves it. Each even data byte goes through one 16x34 multiply and a rounding
//   add, which is the longest path between the input and result registers.
// Reset:
//   arst_n clears the framing position, counters and valid flags; ranges return
//   to 1000 deg/s and 4 g. No clearing pass is needed.
// Stall:
//   A held result blocks only the last byte of the next packet; all other bytes
//   keep flowing, and in_ready drops only when that byte cannot move on.
module imu_fifo_packet_deframer #(
	parameter int unsigned FRAC_BITS = imufd_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Config write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [0:0]                             cfg_index,
	input  logic [imufd_pkg::RANGE_W-1:0]          cfg_data,
	// Byte input channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [7:0]                             fifo_byte,
	// Result output channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             packet_status,
	output logic signed [imufd_pkg::AXIS_W-1:0]    accel_x,
	output logic signed [imufd_pkg::AXIS_W-1:0]    accel_y,
	output logic signed [imufd_pkg::AXIS_W-1:0]    accel_z,
	output logic signed [imufd_pkg::AXIS_W-1:0]    gyro_x,
	output logic signed [imufd_pkg::AXIS_W-1:0]    gyro_y,
	output logic signed [imufd_pkg::AXIS_W-1:0]    gyro_z,
	output logic [imufd_pkg::CNT_W-1:0]            bad_header_total,
	output logic [imufd_pkg::CNT_W-1:0]            packet_total
);

	localparam int unsigned AW = imufd_pkg::AXIS_W;
	localparam int unsigned CW = imufd_pkg::CNT_W;
	localparam logic [CW-1:0] CNT_MAX = '1;

	// Config registers
	logic [imufd_pkg::RANGE_W-1:0] gyro_range_q;
	logic [imufd_pkg::RANGE_W-1:0] accel_range_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Framing state
	logic [imufd_pkg::POS_W-1:0] pos_q;
	logic [7:0]                  header_q;
	logic [7:0]                  hold_q;
	logic signed [AW-1:0]        axis_q [imufd_pkg::NUM_HELD];

	// Result register and counters
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic signed [AW-1:0] res_q [6];
	logic [CW-1:0]        bad_cnt_q;
	logic [CW-1:0]        pkt_cnt_q;

	// Handshake and datapath nets
	logic                    out_free;
	logic                    is_last;
	logic                    adv_s1;
	logic                    emit;
	logic                    is_data_lo;
	logic [2:0]              axis_idx;
	logic [imufd_pkg::POS_W-1:0] pos_m2;
	imufd_pkg::scale_req_t   sreq;
	logic signed [AW-1:0]    scaled;
	imufd_pkg::pkt_status_t  status_d;
	logic [CW-1:0]           bad_cnt_d;
	logic [CW-1:0]           pkt_cnt_d;

	// Config writes: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_range_q  <= imufd_pkg::GYRO_RANGE_RST;
			accel_range_q <= imufd_pkg::ACCEL_RANGE_RST;
		end else if (cfg_valid) begin
			case (imufd_pkg::reg_index_t'(cfg_index))
				imufd_pkg::REG_GYRO_RANGE:  gyro_range_q  <= cfg_data;
				imufd_pkg::REG_ACCEL_RANGE: accel_range_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flow control: only the last byte of a packet needs room in the result register
	assign out_free = !out_valid_q || out_ready;
	assign is_last  = (pos_q == imufd_pkg::PKT_LAST);
	assign adv_s1   = valid_s1 && (!is_last || out_free);
	assign emit     = adv_s1 && is_last;
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= fifo_byte;
		end
	end

	// Axis decode: even positions 2..12 complete an axis
	assign pos_m2     = pos_q - imufd_pkg::POS_W'(2);
	assign axis_idx   = pos_m2[3:1];
	assign is_data_lo = (pos_q != '0) && !pos_q[0];

	assign sreq.raw         = $signed({hold_q, byte_s1});
	assign sreq.is_gyro     = (pos_q >= imufd_pkg::POS_FIRST_GYRO);
	assign sreq.gyro_range  = gyro_range_q;
	assign sreq.accel_range = accel_range_q;

	imufd_axis_scale #(
		.FRAC_BITS(FRAC_BITS)
	) u_scale (
		.req    (sreq),
		.scaled (scaled)
	);

	// Framing position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			header_q <= '0;
			hold_q   <= '0;
		end else if (adv_s1) begin
			pos_q <= is_last ? '0 : pos_q + imufd_pkg::POS_W'(1);
			if (pos_q == '0) begin
				header_q <= byte_s1;
			end else if (pos_q[0]) begin
				hold_q <= byte_s1;
			end
		end
	end

	// Held axis values, written as each of the first five axes completes
	always_ff @(posedge clk) begin
		if (adv_s1 && is_data_lo && !is_last) begin
			axis_q[axis_idx] <= scaled;
		end
	end

	// Header check
	always_comb begin
		if ((header_q & imufd_pkg::HDR_MARKER) != '0) begin
			status_d = imufd_pkg::STAT_MARKER;
		end else if ((header_q & imufd_pkg::HDR_ACCEL_MASK) != imufd_pkg::HDR_ACCEL_16B ||
			(header_q & imufd_pkg::HDR_GYRO_MASK) != imufd_pkg::HDR_GYRO_16B) begin
			status_d = imufd_pkg::STAT_BAD_ENC;
		end else begin
			status_d = imufd_pkg::STAT_GOOD;
		end
	end

	// Saturating counters
	assign pkt_cnt_d = (pkt_cnt_q != CNT_MAX) ? pkt_cnt_q + CW'(1) : pkt_cnt_q;
	assign bad_cnt_d = (status_d != imufd_pkg::STAT_GOOD && bad_cnt_q != CNT_MAX) ?
		bad_cnt_q + CW'(1) : bad_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pkt_cnt_q   <= '0;
			bad_cnt_q   <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				pkt_cnt_q   <= pkt_cnt_d;
				bad_cnt_q   <= bad_cnt_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= status_d;
			for (int k = 0; k < 5; k++) begin
				res_q[k] <= (status_d == imufd_pkg::STAT_GOOD) ? axis_q[k] : '0;
			end
			res_q[5] <= (status_d == imufd_pkg::STAT_GOOD) ? scaled : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign packet_status    = status_q;
	assign accel_x          = res_q[0];
	assign accel_y          = res_q[1];
	assign accel_z          = res_q[2];
	assign gyro_x           = res_q[3];
	assign gyro_y           = res_q[4];
	assign gyro_z           = res_q[5];
	assign bad_header_total = bad_cnt_q;
	assign packet_total     = pkt_cnt_q;

	// Framing position stays inside one packet
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= imufd_pkg::PKT_LAST)
		else $error("framing position beyond last packet byte");

	// Last byte always lands in the result register
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("packet end did not produce a result");

	// Rejected packets never outnumber framed packets
	a_cnt_order: assert property (@(posedge clk) disable iff (!arst_n)
		bad_cnt_q <= pkt_cnt_q)
		else $error("bad header count exceeds packet count");

	// Bad packets carry zero axes (first and last axis checked)
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != imufd_pkg::STAT_GOOD) |->
		(res_q[0] == '0 && res_q[5] == '0))
		else $error("bad packet with nonzero axis data");

	// Packet counter advances by one per emitted result until saturation
	a_pkt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pkt_cnt_q != CNT_MAX) |=> pkt_cnt_q == $past(pkt_cnt_q) + CW'(1))
		else $error("packet counter step wrong");

endmodule

@@ rtl/imufd_axis_scale.sv @@
// Axis scaler: raw 16-bit sample times range factor, rounded to FRAC_BITS fraction bits.
module imufd_axis_scale #(
	parameter int unsigned FRAC_BITS = imufd_pkg::FRAC_BITS_DEFAULT
) (
	input  imufd_pkg::scale_req_t                     req,
	output logic signed [imufd_pkg::AXIS_W-1:0]       scaled
);

	localparam int unsigned SHIFT  = imufd_pkg::FACTOR_FRAC - FRAC_BITS;
	localparam int unsigned PROD_W = imufd_pkg::RAW_W + imufd_pkg::FACTOR_W + 1;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (SHIFT - 1);

	logic [imufd_pkg::FACTOR_W-1:0] factor;
	logic signed [PROD_W-1:0]       prod;
	logic signed [PROD_W-1:0]       rounded;
	logic signed [PROD_W-1:0]       shifted;

	// Factor lookup per sensor type
	always_comb begin
		if (req.is_gyro) begin
			factor = imufd_pkg::gyro_factor(req.gyro_range);
		end else begin
			factor = imufd_pkg::accel_factor(req.accel_range);
		end
	end

	// Signed multiply, round half up, arithmetic shift down
	assign prod    = PROD_W'(req.raw) * $signed({1'b0, factor});
	assign rounded = prod + HALF;
	assign shifted = rounded >>> SHIFT;
	assign scaled  = shifted[imufd_pkg::AXIS_W-1:0];

endmodule
